### rtl/rwlt_pkg.sv
// shared types, constants and codes of the reader/writer lock table
`default_nettype none
package rwlt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int MAX_READERS   = 4;
   localparam int BATCH_SLOTS   = 8;
   localparam int OWNER_BITS    = 8;

   localparam int SLOT_W = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1;
   localparam int CNT_W  = $clog2(BATCH_SLOTS + 1);

   typedef enum logic [1:0] {
      OP_STAGE   = 2'd0,
      OP_ACQUIRE = 2'd1,
      OP_RELEASE = 2'd2,
      OP_FREE    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_IN_USE    = 3'd1,
      ST_HAS_WRITE = 3'd2,
      ST_HAS_READ  = 3'd3,
      ST_NO_WRITE  = 3'd4,
      ST_NO_READ   = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   localparam int MODE_EXCL = 0;
   localparam int MODE_SHRD = 1;

   typedef enum logic [3:0] {
      CELL_NOP      = 4'd0,
      CELL_SET_WR   = 4'd1,
      CELL_ALLOC_WR = 4'd2,
      CELL_ADD_RD   = 4'd3,
      CELL_ALLOC_RD = 4'd4,
      CELL_CLR_WR   = 4'd5,
      CELL_CLR_RD   = 4'd6,
      CELL_FREE_OWN = 4'd7,
      CELL_SAVE     = 4'd8,
      CELL_RESTORE  = 4'd9
   } cell_op_type;

   typedef struct packed {
      logic [23:0] class_type;
      logic [31:0] object_id;
      logic [15:0] extra;
   } key_type;

   typedef struct packed {
      cell_op_type             op;
      key_type                 key;
      logic [OWNER_BITS-1:0]   own;
   } cmd_type;

   // per-entry view of the current request, muxed by the hit select
   typedef struct packed {
      status_type w_st;
      status_type r_st;
      logic       rd_full;
      logic       rd_has_own;
      logic       wr_vld;
   } info_type;

endpackage
`default_nettype wire

### rtl/reader_writer_lock_table.sv
// top level: request sequencer, staged batch slots and the row of lock entry cells
//
//   channel | ports                          | direction
//   request | req_valid/req_ready + fields   | in
//   result  | rsp_valid/rsp_ready + fields   | out
//
// stage requests go straight to the result and free-owner requests take one free step;
// acquire and release walk the batch item by item (fetch, exclusive part, shared part),
// and a multi-item acquire runs a check pass, save, commit pass and optional rollback.
// each step is one match against all entries at once through the cell chain.
// reset clears every entry and the result valid flag; staged slots hold no reset value.
// a finished result waits in the output register; the next request is taken meanwhile.
`default_nettype none
module reader_writer_lock_table (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_opcode,
   input  wire  [2:0]  req_slot_index,
   input  wire  [7:0]  req_lock_class,
   input  wire  [15:0] req_type_id,
   input  wire  [31:0] req_object_id,
   input  wire  [15:0] req_extra_key,
   input  wire  [1:0]  req_lock_mode,
   input  wire  [7:0]  req_owner_id,
   input  wire  [3:0]  req_batch_count,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_failed_slot
);
   import rwlt_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_FETCH   = 8'b0000_0010,
      S_WPART   = 8'b0000_0100,
      S_RPART   = 8'b0000_1000,
      S_SAVE    = 8'b0001_0000,
      S_RESTORE = 8'b0010_0000,
      S_FREE    = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      PH_CHECK   = 2'd0,
      PH_COMMIT  = 2'd1,
      PH_RELEASE = 2'd2
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [CNT_W-1:0] idx_ff, idx_in, n_ff, n_in;
   logic multi_ff, multi_in;
   logic [OWNER_BITS-1:0] own_ff, own_in;
   key_type cur_key_ff;
   logic [1:0] cur_mode_ff;
   status_type res_st_ff, res_st_in;
   logic [2:0] res_slot_ff, res_slot_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   logic [2:0] rsp_slot_ff;

   key_type    stg_key [BATCH_SLOTS];
   logic [1:0] stg_mode [BATCH_SLOTS];

   cmd_type cmd;
   logic [TABLE_ENTRIES-1:0] cell_sel, first_hit, first_free;
   logic [TABLE_ENTRIES:0]   hit_chain, free_chain;
   info_type cell_info [TABLE_ENTRIES];
   info_type hit_info;
   logic hit_any, free_any, step_fail;
   status_type fail_code;
   logic accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign hit_chain[0]  = 1'b0;
   assign free_chain[0] = 1'b0;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      rwlt_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .cmd             (cmd),
         .sel             (cell_sel[g]),
         .hit_before_in   (hit_chain[g]),
         .free_before_in  (free_chain[g]),
         .hit_before_out  (hit_chain[g+1]),
         .free_before_out (free_chain[g+1]),
         .first_hit       (first_hit[g]),
         .first_free      (first_free[g]),
         .info            (cell_info[g])
      );
   end

   assign hit_any  = hit_chain[TABLE_ENTRIES];
   assign free_any = free_chain[TABLE_ENTRIES];

   always_comb begin
      hit_info = '0;
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
         hit_info = hit_info | (cell_info[e] & {$bits(info_type){first_hit[e]}});
      end
   end

   // per-step decision: command to the cells, or failure of this item
   always_comb begin
      cmd.key   = cur_key_ff;
      cmd.own   = own_ff;
      cmd.op    = CELL_NOP;
      cell_sel  = '0;
      step_fail = 1'b0;
      fail_code = ST_OK;
      case (state_ff)
         S_WPART: begin
            if (cur_mode_ff[MODE_EXCL]) begin
               if (phase_ff == PH_RELEASE) begin
                  if (!hit_any || !hit_info.wr_vld) begin
                     step_fail = 1'b1;
                     fail_code = ST_NO_WRITE;
                  end else begin
                     cmd.op   = CELL_CLR_WR;
                     cell_sel = first_hit;
                  end
               end else if (hit_any && hit_info.w_st != ST_OK) begin
                  step_fail = 1'b1;
                  fail_code = hit_info.w_st;
               end else if (phase_ff == PH_COMMIT) begin
                  if (hit_any) begin
                     cmd.op   = CELL_SET_WR;
                     cell_sel = first_hit;
                  end else if (free_any) begin
                     cmd.op   = CELL_ALLOC_WR;
                     cell_sel = first_free;
                  end else begin
                     step_fail = 1'b1;
                     fail_code = ST_FULL;
                  end
               end
            end
         end
         S_RPART: begin
            if (cur_mode_ff[MODE_SHRD]) begin
               if (phase_ff == PH_RELEASE) begin
                  if (!hit_any || !hit_info.rd_has_own) begin
                     step_fail = 1'b1;
                     fail_code = ST_NO_READ;
                  end else begin
                     cmd.op   = CELL_CLR_RD;
                     cell_sel = first_hit;
                  end
               end else if (hit_any && hit_info.r_st != ST_OK) begin
                  step_fail = 1'b1;
                  fail_code = hit_info.r_st;
               end else if (phase_ff == PH_COMMIT) begin
                  if (hit_any) begin
                     if (hit_info.rd_full) begin
                        step_fail = 1'b1;
                        fail_code = ST_FULL;
                     end else begin
                        cmd.op   = CELL_ADD_RD;
                        cell_sel = first_hit;
                     end
                  end else if (free_any) begin
                     cmd.op   = CELL_ALLOC_RD;
                     cell_sel = first_free;
                  end else begin
                     step_fail = 1'b1;
                     fail_code = ST_FULL;
                  end
               end
            end
         end
         S_SAVE:    cmd.op = CELL_SAVE;
         S_RESTORE: cmd.op = CELL_RESTORE;
         S_FREE:    cmd.op = CELL_FREE_OWN;
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      multi_in     = multi_ff;
      own_in       = own_ff;
      res_st_in    = res_st_ff;
      res_slot_in  = res_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               own_in      = req_owner_id[OWNER_BITS-1:0];
               res_st_in   = ST_OK;
               res_slot_in = 3'd0;
               idx_in      = '0;
               if (req_batch_count > BATCH_SLOTS) begin
                  n_in = CNT_W'(BATCH_SLOTS);
               end else begin
                  n_in = CNT_W'(req_batch_count);
               end
               multi_in = (req_batch_count > 4'd1);
               case (opcode_type'(req_opcode))
                  OP_STAGE: state_in = S_DONE;
                  OP_FREE:  state_in = S_FREE;
                  OP_ACQUIRE: begin
                     phase_in = (req_batch_count == 4'd1) ? PH_COMMIT : PH_CHECK;
                     state_in = (req_batch_count == 4'd0) ? S_DONE : S_FETCH;
                  end
                  default: begin
                     phase_in = PH_RELEASE;
                     state_in = (req_batch_count == 4'd0) ? S_DONE : S_FETCH;
                  end
               endcase
            end
         end
         S_FETCH: state_in = S_WPART;
         S_WPART, S_RPART: begin
            if (step_fail) begin
               res_st_in   = fail_code;
               res_slot_in = 3'(idx_ff);
               state_in    = (phase_ff == PH_COMMIT && multi_ff) ? S_RESTORE : S_DONE;
            end else if (state_ff == S_WPART) begin
               state_in = S_RPART;
            end else if (idx_ff + 1'b1 == n_ff) begin
               state_in = (phase_ff == PH_CHECK) ? S_SAVE : S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_FETCH;
            end
         end
         S_SAVE: begin
            phase_in = PH_COMMIT;
            idx_in   = '0;
            state_in = S_FETCH;
         end
         S_RESTORE: state_in = S_DONE;
         S_FREE:    state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && opcode_type'(req_opcode) == OP_STAGE && req_slot_index < BATCH_SLOTS) begin
         stg_key[req_slot_index[SLOT_W-1:0]]  <= {req_lock_class, req_type_id,
                                                  req_object_id, req_extra_key};
         stg_mode[req_slot_index[SLOT_W-1:0]] <= req_lock_mode;
      end
      if (state_ff == S_FETCH) begin
         cur_key_ff  <= stg_key[idx_ff[SLOT_W-1:0]];
         cur_mode_ff <= stg_mode[idx_ff[SLOT_W-1:0]];
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_status_ff <= res_st_ff;
         rsp_slot_ff   <= (res_st_ff == ST_OK) ? 3'd0 : res_slot_ff;
      end
      phase_ff    <= phase_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      multi_ff    <= multi_in;
      own_ff      <= own_in;
      res_st_ff   <= res_st_in;
      res_slot_ff <= res_slot_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_failed_slot = rsp_slot_ff;

endmodule
`default_nettype wire

### rtl/rwlt_cell.sv
// one lock table entry with its writer, reader list and rollback copy
`default_nettype none
module rwlt_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  wire rwlt_pkg::cmd_type   cmd,
   input  wire                      sel,
   input  wire                      hit_before_in,
   input  wire                      free_before_in,
   output logic                     hit_before_out,
   output logic                     free_before_out,
   output logic                     first_hit,
   output logic                     first_free,
   output rwlt_pkg::info_type       info
);
   import rwlt_pkg::*;

   logic                  valid_ff, valid_in;
   key_type               key_ff, key_in;
   logic                  wr_vld_ff, wr_vld_in;
   logic [OWNER_BITS-1:0] wr_own_ff, wr_own_in;
   logic [MAX_READERS-1:0] rd_vld_ff, rd_vld_in;
   logic [OWNER_BITS-1:0] rd_own_ff [MAX_READERS];
   logic [OWNER_BITS-1:0] rd_own_in [MAX_READERS];

   logic                   sv_valid_ff, sv_wr_vld_ff;
   logic [OWNER_BITS-1:0]  sv_wr_own_ff;
   logic [MAX_READERS-1:0] sv_rd_vld_ff;
   logic [OWNER_BITS-1:0]  sv_rd_own_ff [MAX_READERS];

   logic                   hit, wr_is_own, rd_has_own;
   logic [MAX_READERS-1:0] own_match, own_first, free_first;

   always_comb begin
      logic found_own, found_free;
      found_own  = 1'b0;
      found_free = 1'b0;
      for (int r = 0; r < MAX_READERS; r++) begin
         own_match[r]  = rd_vld_ff[r] && (rd_own_ff[r] == cmd.own);
         own_first[r]  = own_match[r] && !found_own;
         free_first[r] = !rd_vld_ff[r] && !found_free;
         found_own     = found_own || own_match[r];
         found_free    = found_free || !rd_vld_ff[r];
      end
   end

   assign hit        = valid_ff && (key_ff == cmd.key);
   assign wr_is_own  = wr_vld_ff && (wr_own_ff == cmd.own);
   assign rd_has_own = |own_match;

   // priority chain: only the first hit and the first free entry answer
   assign hit_before_out  = hit_before_in || hit;
   assign free_before_out = free_before_in || !valid_ff;
   assign first_hit       = hit && !hit_before_in;
   assign first_free      = !valid_ff && !free_before_in;

   always_comb begin
      if (($countones(rd_vld_ff) >= 2) || (($countones(rd_vld_ff) == 1) && !rd_has_own)) begin
         info.w_st = ST_IN_USE;
      end else if (wr_vld_ff) begin
         info.w_st = wr_is_own ? ST_HAS_WRITE : ST_IN_USE;
      end else begin
         info.w_st = ST_OK;
      end
      if (wr_vld_ff && !wr_is_own) begin
         info.r_st = ST_IN_USE;
      end else if (rd_has_own) begin
         info.r_st = ST_HAS_READ;
      end else begin
         info.r_st = ST_OK;
      end
      info.rd_full    = &rd_vld_ff;
      info.rd_has_own = rd_has_own;
      info.wr_vld     = wr_vld_ff;
   end

   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      wr_vld_in = wr_vld_ff;
      wr_own_in = wr_own_ff;
      rd_vld_in = rd_vld_ff;
      rd_own_in = rd_own_ff;
      case (cmd.op)
         CELL_SET_WR: begin
            if (sel) begin
               wr_vld_in = 1'b1;
               wr_own_in = cmd.own;
            end
         end
         CELL_ALLOC_WR: begin
            if (sel) begin
               valid_in  = 1'b1;
               key_in    = cmd.key;
               wr_vld_in = 1'b1;
               wr_own_in = cmd.own;
               rd_vld_in = '0;
            end
         end
         CELL_ADD_RD: begin
            if (sel) begin
               rd_vld_in = rd_vld_ff | free_first;
               for (int r = 0; r < MAX_READERS; r++) begin
                  if (free_first[r]) begin
                     rd_own_in[r] = cmd.own;
                  end
               end
            end
         end
         CELL_ALLOC_RD: begin
            if (sel) begin
               valid_in     = 1'b1;
               key_in       = cmd.key;
               wr_vld_in    = 1'b0;
               rd_vld_in    = '0;
               rd_vld_in[0] = 1'b1;
               rd_own_in[0] = cmd.own;
            end
         end
         CELL_CLR_WR: begin
            if (sel) begin
               wr_vld_in = 1'b0;
               valid_in  = |rd_vld_ff;
            end
         end
         CELL_CLR_RD: begin
            if (sel) begin
               rd_vld_in = rd_vld_ff & ~own_first;
               valid_in  = wr_vld_ff || (|(rd_vld_ff & ~own_first));
            end
         end
         CELL_FREE_OWN: begin
            if (valid_ff) begin
               wr_vld_in = wr_vld_ff && !wr_is_own;
               rd_vld_in = rd_vld_ff & ~own_match;
               valid_in  = (wr_vld_ff && !wr_is_own) || (|(rd_vld_ff & ~own_match));
            end
         end
         CELL_RESTORE: begin
            valid_in  = sv_valid_ff;
            wr_vld_in = sv_wr_vld_ff;
            wr_own_in = sv_wr_own_ff;
            rd_vld_in = sv_rd_vld_ff;
            rd_own_in = sv_rd_own_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      wr_own_ff <= wr_own_in;
      rd_own_ff <= rd_own_in;
      if (cmd.op == CELL_SAVE) begin
         sv_wr_own_ff <= wr_own_ff;
         sv_rd_own_ff <= rd_own_ff;
      end
      if (reset) begin
         valid_ff     <= 1'b0;
         wr_vld_ff    <= 1'b0;
         rd_vld_ff    <= '0;
         sv_valid_ff  <= 1'b0;
         sv_wr_vld_ff <= 1'b0;
         sv_rd_vld_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         wr_vld_ff <= wr_vld_in;
         rd_vld_ff <= rd_vld_in;
         if (cmd.op == CELL_SAVE) begin
            sv_valid_ff  <= valid_ff;
            sv_wr_vld_ff <= wr_vld_ff;
            sv_rd_vld_ff <= rd_vld_ff;
         end
      end
   end

endmodule
`default_nettype wire

### test/tb.sv
// self-checking testbench for the reader/writer lock table
`default_nettype none
module tb;
   import rwlt_pkg::*;

   typedef struct packed {
      status_type  st;
      logic [2:0]  slot;
   } lock_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_STAGE;
   logic [2:0]  req_slot_index = '0;
   logic [7:0]  req_lock_class = '0;
   logic [15:0] req_type_id = '0;
   logic [31:0] req_object_id = '0;
   logic [15:0] req_extra_key = '0;
   logic [1:0]  req_lock_mode = '0;
   logic [7:0]  req_owner_id = '0;
   logic [3:0]  req_batch_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_failed_slot;

   reader_writer_lock_table i_dut (.*);

   always #4 clock = ~clock;

   // lock table mirror
   logic        ent_vld [TABLE_ENTRIES];
   logic [23:0] ent_ct  [TABLE_ENTRIES];
   logic [31:0] ent_obj [TABLE_ENTRIES];
   logic [15:0] ent_ex  [TABLE_ENTRIES];
   logic [8:0]  wr_own  [TABLE_ENTRIES];
   logic [8:0]  rd_own  [TABLE_ENTRIES*MAX_READERS];
   logic        sv_vld  [TABLE_ENTRIES];
   logic [23:0] sv_ct   [TABLE_ENTRIES];
   logic [31:0] sv_obj  [TABLE_ENTRIES];
   logic [15:0] sv_ex   [TABLE_ENTRIES];
   logic [8:0]  sv_wr   [TABLE_ENTRIES];
   logic [8:0]  sv_rd   [TABLE_ENTRIES*MAX_READERS];
   logic [23:0] stg_ct  [BATCH_SLOTS];
   logic [31:0] stg_obj [BATCH_SLOTS];
   logic [15:0] stg_ex  [BATCH_SLOTS];
   logic [1:0]  stg_mode[BATCH_SLOTS];

   lock_result_type lock_results_due[$];
   int  errors = 0;
   int  cycles = 0;
   int  sent = 0;
   bit  calm = 1'b0;

   // key pool for the random part
   logic [23:0] pool_ct [24];
   logic [31:0] pool_obj[24];
   logic [15:0] pool_ex [24];
   logic [7:0]  owners  [6];

   function automatic int find_key(logic [23:0] ct, logic [31:0] obj, logic [15:0] ex);
      for (int e = 0; e < TABLE_ENTRIES; e++)
         if (ent_vld[e] && ent_ct[e] == ct && ent_obj[e] == obj && ent_ex[e] == ex)
            return e;
      return -1;
   endfunction

   function automatic int alloc_key(logic [23:0] ct, logic [31:0] obj, logic [15:0] ex);
      for (int e = 0; e < TABLE_ENTRIES; e++)
         if (!ent_vld[e]) begin
            ent_vld[e] = 1'b1;
            ent_ct[e]  = ct;
            ent_obj[e] = obj;
            ent_ex[e]  = ex;
            wr_own[e]  = '0;
            for (int r = 0; r < MAX_READERS; r++) rd_own[e*MAX_READERS+r] = '0;
            return e;
         end
      return -1;
   endfunction

   function automatic void tidy(int e);
      if (wr_own[e][8]) return;
      for (int r = 0; r < MAX_READERS; r++)
         if (rd_own[e*MAX_READERS+r][8]) return;
      ent_vld[e] = 1'b0;
   endfunction

   function automatic status_type check_excl(logic [8:0] own, int e);
      int cnt;
      logic [8:0] last;
      cnt = 0;
      last = '0;
      if (e < 0) return ST_OK;
      for (int r = 0; r < MAX_READERS; r++)
         if (rd_own[e*MAX_READERS+r][8]) begin
            cnt++;
            last = rd_own[e*MAX_READERS+r];
         end
      // a lone reader may upgrade to exclusive
      if (cnt >= 2 || (cnt == 1 && last != own)) return ST_IN_USE;
      if (wr_own[e][8]) return (wr_own[e] == own) ? ST_HAS_WRITE : ST_IN_USE;
      return ST_OK;
   endfunction

   function automatic status_type check_shrd(logic [8:0] own, int e);
      if (e < 0) return ST_OK;
      if (wr_own[e][8] && wr_own[e] != own) return ST_IN_USE;
      for (int r = 0; r < MAX_READERS; r++)
         if (rd_own[e*MAX_READERS+r] == own) return ST_HAS_READ;
      return ST_OK;
   endfunction

   function automatic status_type lock_item(int s, logic [8:0] own, bit commit);
      int e;
      bit placed, fresh;
      status_type st;
      placed = 0;
      fresh = 0;
      if (stg_mode[s][MODE_EXCL]) begin
         e = find_key(stg_ct[s], stg_obj[s], stg_ex[s]);
         st = check_excl(own, e);
         if (st != ST_OK) return st;
         if (commit) begin
            if (e < 0) e = alloc_key(stg_ct[s], stg_obj[s], stg_ex[s]);
            if (e < 0) return ST_FULL;
            wr_own[e] = own;
         end
      end
      if (stg_mode[s][MODE_SHRD]) begin
         e = find_key(stg_ct[s], stg_obj[s], stg_ex[s]);
         st = check_shrd(own, e);
         if (st != ST_OK) return st;
         if (commit) begin
            if (e < 0) begin
               e = alloc_key(stg_ct[s], stg_obj[s], stg_ex[s]);
               fresh = 1;
            end
            if (e < 0) return ST_FULL;
            for (int r = 0; r < MAX_READERS && !placed; r++)
               if (!rd_own[e*MAX_READERS+r][8]) begin
                  rd_own[e*MAX_READERS+r] = own;
                  placed = 1;
               end
            if (!placed) begin
               if (fresh) tidy(e);
               return ST_FULL;
            end
         end
      end
      return ST_OK;
   endfunction

   function automatic status_type unlock_item(int s, logic [8:0] own);
      int e;
      bit hit;
      hit = 0;
      if (stg_mode[s][MODE_EXCL]) begin
         e = find_key(stg_ct[s], stg_obj[s], stg_ex[s]);
         // owner of the exclusive lock is not checked
         if (e < 0 || !wr_own[e][8]) return ST_NO_WRITE;
         wr_own[e] = '0;
         tidy(e);
      end
      if (stg_mode[s][MODE_SHRD]) begin
         e = find_key(stg_ct[s], stg_obj[s], stg_ex[s]);
         if (e < 0) return ST_NO_READ;
         for (int r = 0; r < MAX_READERS && !hit; r++)
            if (rd_own[e*MAX_READERS+r] == own) begin
               rd_own[e*MAX_READERS+r] = '0;
               hit = 1;
            end
         if (!hit) return ST_NO_READ;
         tidy(e);
      end
      return ST_OK;
   endfunction

   function automatic void copy_table(bit to_saved);
      for (int e = 0; e < TABLE_ENTRIES; e++)
         if (to_saved) begin
            sv_vld[e] = ent_vld[e]; sv_ct[e] = ent_ct[e]; sv_obj[e] = ent_obj[e];
            sv_ex[e] = ent_ex[e]; sv_wr[e] = wr_own[e];
         end else begin
            ent_vld[e] = sv_vld[e]; ent_ct[e] = sv_ct[e]; ent_obj[e] = sv_obj[e];
            ent_ex[e] = sv_ex[e]; wr_own[e] = sv_wr[e];
         end
      for (int r = 0; r < TABLE_ENTRIES*MAX_READERS; r++)
         if (to_saved) sv_rd[r] = rd_own[r];
         else rd_own[r] = sv_rd[r];
   endfunction

   function automatic lock_result_type predict_lock_result();
      lock_result_type res;
      logic [8:0] own;
      int n, fail;
      status_type st;
      own = {1'b1, req_owner_id};
      n = (req_batch_count > BATCH_SLOTS) ? BATCH_SLOTS : req_batch_count;
      st = ST_OK;
      fail = 0;
      case (req_opcode)
         OP_STAGE: begin
            stg_ct[req_slot_index]   = {req_lock_class, req_type_id};
            stg_obj[req_slot_index]  = req_object_id;
            stg_ex[req_slot_index]   = req_extra_key;
            stg_mode[req_slot_index] = req_lock_mode;
         end
         OP_ACQUIRE: begin
            if (n == 1) st = lock_item(0, own, 1);
            else if (n > 1) begin
               for (int i = 0; i < n && st == ST_OK; i++) begin
                  st = lock_item(i, own, 0);
                  if (st != ST_OK) fail = i;
               end
               if (st == ST_OK) begin
                  copy_table(1);
                  for (int i = 0; i < n && st == ST_OK; i++) begin
                     st = lock_item(i, own, 1);
                     if (st != ST_OK) fail = i;
                  end
                  if (st != ST_OK) copy_table(0);
               end
            end
         end
         OP_RELEASE: begin
            for (int i = 0; i < n && st == ST_OK; i++) begin
               st = unlock_item(i, own);
               if (st != ST_OK) fail = i;
            end
         end
         default: begin
            for (int e = 0; e < TABLE_ENTRIES; e++)
               if (ent_vld[e]) begin
                  if (wr_own[e] == own) wr_own[e] = '0;
                  for (int r = 0; r < MAX_READERS; r++)
                     if (rd_own[e*MAX_READERS+r] == own) rd_own[e*MAX_READERS+r] = '0;
                  tidy(e);
               end
         end
      endcase
      res.st = st;
      res.slot = (st == ST_OK) ? 3'd0 : fail[2:0];
      return res;
   endfunction

   task automatic send_request(opcode_type op, logic [2:0] slot, logic [23:0] ct,
                               logic [31:0] obj, logic [15:0] ex, logic [1:0] mode,
                               logic [7:0] owner, logic [3:0] cnt);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_slot_index  <= slot;
      req_lock_class  <= ct[23:16];
      req_type_id     <= ct[15:0];
      req_object_id   <= obj;
      req_extra_key   <= ex;
      req_lock_mode   <= mode;
      req_owner_id    <= owner;
      req_batch_count <= cnt;
      do @(posedge clock); while (!req_ready);
      lock_results_due.push_back(predict_lock_result());
      sent++;
      if (!calm && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 11)) @(negedge clock);
      end
   endtask

   // key fields of a non-stage request are don't-care, so they get random bits
   task automatic send_command(opcode_type op, logic [7:0] owner, logic [3:0] cnt);
      send_request(op, 3'($urandom), 24'($urandom), $urandom, 16'($urandom), 2'($urandom),
                   owner, cnt);
   endtask

   task automatic stage_pool(int s, int k, logic [1:0] mode);
      send_request(OP_STAGE, 3'(s), pool_ct[k], pool_obj[k], pool_ex[k], mode,
                   8'($urandom), 4'($urandom));
   endtask

   task automatic test_directed;
      send_request(OP_STAGE, 3'd0, 24'hffffff, 32'hffffffff, 16'hffff, 2'd1, 8'h00, 4'hf);
      send_request(OP_STAGE, 3'd1, 24'h000000, 32'h00000000, 16'h0000, 2'd2, 8'hff, 4'h0);
      for (int s = 2; s < BATCH_SLOTS; s++)
         send_request(OP_STAGE, 3'(s), 24'($urandom), $urandom, 16'($urandom), 2'd3,
                      8'($urandom), 4'($urandom));
      send_command(OP_ACQUIRE, 8'h00, 4'd1);   // exclusive ok
      send_command(OP_ACQUIRE, 8'h00, 4'd1);   // already has write
      send_command(OP_ACQUIRE, 8'hff, 4'd1);   // in use
      send_command(OP_RELEASE, 8'h00, 4'd1);
      send_command(OP_RELEASE, 8'h00, 4'd1);   // nothing to release
      send_command(OP_ACQUIRE, 8'h00, 4'd0);   // empty batch
      send_command(OP_ACQUIRE, 8'h00, 4'd2);
      send_command(OP_ACQUIRE, 8'hff, 4'd2);   // check pass refuses
      send_request(OP_STAGE, 3'd0, 24'h000000, 32'h00000000, 16'h0000, 2'd2, 8'h00, 4'h0);
      send_command(OP_ACQUIRE, 8'hff, 4'd1);   // second reader
      send_request(OP_STAGE, 3'd0, 24'h000000, 32'h00000000, 16'h0000, 2'd1, 8'h00, 4'h0);
      send_command(OP_ACQUIRE, 8'h00, 4'd1);   // two readers block exclusive
      send_request(OP_STAGE, 3'd0, 24'h000000, 32'h00000000, 16'h0000, 2'd2, 8'h00, 4'h0);
      send_command(OP_RELEASE, 8'hff, 4'd1);
      send_request(OP_STAGE, 3'd0, 24'h000000, 32'h00000000, 16'h0000, 2'd3, 8'h00, 4'h0);
      send_command(OP_ACQUIRE, 8'h00, 4'd1);   // lone reader upgrades, shared part fails
      send_command(OP_ACQUIRE, 8'hff, 4'd15);  // count saturates
      send_command(OP_RELEASE, 8'hff, 4'd1);   // write freed, read missing
      send_request(OP_STAGE, 3'd0, 24'h000000, 32'h00000000, 16'h0000, 2'd0, 8'h00, 4'h0);
      send_command(OP_ACQUIRE, 8'h00, 4'd1);   // mode zero
      send_command(OP_FREE, 8'h00, 4'd0);
   endtask

   task automatic test_random(int total);
      int n, k;
      for (int k2 = 0; k2 < 24; k2++) begin
         pool_ct[k2] = 24'($urandom); pool_obj[k2] = $urandom; pool_ex[k2] = 16'($urandom);
      end
      owners[0] = 8'h00;
      owners[1] = 8'hff;
      for (int o = 2; o < 6; o++) owners[o] = 8'($urandom);
      while (sent < total) begin
         if (sent > total - 150) calm = 1'b1;
         k = $urandom_range(0, 19);
         if (k < 15) begin
            // well-formed batch: stage then acquire or release
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
            for (int s = 0; s < n && s < BATCH_SLOTS; s++)
               stage_pool(s, $urandom_range(0, 23), ($urandom_range(0, 9) == 0) ? 2'd0 :
                          2'($urandom_range(1, 3)));
            send_command(k < 11 ? OP_ACQUIRE : OP_RELEASE, owners[$urandom_range(0, 5)],
                         4'(n));
         end else if (k < 17)
            send_command(OP_FREE,
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                         owners[$urandom_range(0, 5)],
                         4'($urandom));
         else if (k < 19)
            send_request(OP_STAGE, 3'($urandom), 24'($urandom), $urandom, 16'($urandom),
                         2'($urandom), 8'($urandom), 4'($urandom));
         else
            send_command($urandom_range(0, 1) ? OP_ACQUIRE : OP_RELEASE, 8'($urandom),
                         4'($urandom_range(0, 15)));
      end
   endtask

   // result stalls in random bursts
   int stall_hold = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_hold > 0) stall_hold--;
         else if (rsp_ready && !calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            stall_hold = $urandom_range(0, 11);
         end else if (!rsp_ready) begin
            rsp_ready <= 1'b1;
            stall_hold = $urandom_range(0, 30);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (lock_results_due.size() == 0) begin
            $display("%0t: unexpected response status %0d slot %0d", $time,
                     rsp_status, rsp_failed_slot);
            errors++;
         end else begin
            lock_result_type want;
            want = lock_results_due.pop_front();
            if (rsp_status !== want.st) begin
               $display("%0t: status expected %0d actual %0d", $time, want.st, rsp_status);
               errors++;
            end
            if (rsp_failed_slot !== want.slot) begin
               $display("%0t: failed_slot expected %0d actual %0d", $time, want.slot,
                        rsp_failed_slot);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 600000) begin
         $display("reader_writer_lock_table verification failed");
         $finish;
      end
   end

   initial begin
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
         ent_vld[e] = 1'b0; wr_own[e] = '0;
      end
      for (int r = 0; r < TABLE_ENTRIES*MAX_READERS; r++) rd_own[r] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1350);
      @(negedge clock);
      req_valid <= 1'b0;
      while (lock_results_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("reader_writer_lock_table verification clean");
      else
         $display("reader_writer_lock_table verification failed");
      $finish;
   end

endmodule
`default_nettype wire
